@@ design/bss_pkg.sv @@
// ---------------------------------------------------------------------------
// bss_pkg
// shared types and constants of the battery safety supervisor
// ---------------------------------------------------------------------------
package bss_pkg;

    localparam int TIMER_BITS = 16;
    localparam int VOLT_W     = 14;
    localparam int ELAPSED_W  = 16;
    localparam int RATE_W     = 14;
    localparam int PROD_W     = RATE_W + ELAPSED_W;
    localparam int FRAC_W     = 10;
    localparam int QUOT_W     = 21;

    // floor(x / 1000) = (x * RECIP_K) >> RECIP_SHIFT, exact for x below 2**30
    localparam int             RECIP_SHIFT = 40;
    localparam int             RECIP_W     = 31;
    localparam logic [30:0]    RECIP_K     = 31'd1099511628;
    localparam int             MULT_W      = PROD_W + RECIP_W;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    localparam logic [VOLT_W-1:0] TEN_VOLTS_MV = 14'd10000;
    localparam logic [VOLT_W-1:0] MV_SAT       = 14'd16383;
    localparam logic [FRAC_W-1:0] UV_PER_MV    = 10'd1000;

    // configuration register indexes
    localparam logic [2:0] REG_CRITICAL_MV   = 3'd0;
    localparam logic [2:0] REG_WARNING_MV    = 3'd1;
    localparam logic [2:0] REG_NEAR_MARGIN   = 3'd2;
    localparam logic [2:0] REG_RECOVERY_RATE = 3'd3;
    localparam logic [2:0] REG_CRIT_COOLDOWN = 3'd4;
    localparam logic [2:0] REG_WARN_COOLDOWN = 3'd5;
    localparam logic [2:0] REG_MONITOR_EN    = 3'd6;

    // item functions
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // safety states
    localparam logic [1:0] ST_CLEAR     = 2'd0;
    localparam logic [1:0] ST_OPER_LOSS = 2'd1;
    localparam logic [1:0] ST_CONN_LOSS = 2'd2;
    localparam logic [1:0] ST_STOP      = 2'd3;

    // battery events
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_CRITICAL = 2'd1;
    localparam logic [1:0] EV_NEAR     = 2'd2;
    localparam logic [1:0] EV_LOW      = 2'd3;

    typedef struct packed {
        logic                 func;
        logic [VOLT_W-1:0]    voltage_mv;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 external_fault;
        logic                 operator_lost;
        logic                 link_lost;
    } item_t;

endpackage

@@ design/bss_split.sv @@
// ---------------------------------------------------------------------------
// bss_split
// two-stage split of the recovery increment into millivolts and microvolts
// ---------------------------------------------------------------------------
module bss_split
    import bss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  item_t             in_item,
    input  logic [PROD_W-1:0] in_prod,
    output logic              out_valid,
    output item_t             out_item,
    output logic [VOLT_W-1:0] out_mv,
    output logic [FRAC_W-1:0] out_frac
);

    logic              b_valid_reg;
    item_t             b_item_reg;
    logic [PROD_W-1:0] b_prod_reg;
    logic [QUOT_W-1:0] b_quot_reg;
    logic [QUOT_W-1:0] b_quot_next;
    logic [MULT_W-1:0] recip_prod;

    logic              c_valid_reg;
    item_t             c_item_reg;
    logic [VOLT_W-1:0] c_mv_reg;
    logic [VOLT_W-1:0] c_mv_next;
    logic [FRAC_W-1:0] c_frac_reg;
    logic [FRAC_W-1:0] c_frac_next;
    logic [PROD_W-1:0] rem_full;

    // quotient by reciprocal multiply
    assign recip_prod  = MULT_W'(in_prod) * MULT_W'(RECIP_K);
    assign b_quot_next = recip_prod[RECIP_SHIFT +: QUOT_W];

    // remainder and saturation of the millivolt part
    assign rem_full    = b_prod_reg - (PROD_W'(b_quot_reg) * PROD_W'(UV_PER_MV));
    assign c_frac_next = rem_full[FRAC_W-1:0];
    assign c_mv_next   = (b_quot_reg > QUOT_W'(MV_SAT)) ? MV_SAT : b_quot_reg[VOLT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= in_valid;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_item_reg <= in_item;
            b_prod_reg <= in_prod;
            b_quot_reg <= b_quot_next;
            c_item_reg <= b_item_reg;
            c_mv_reg   <= c_mv_next;
            c_frac_reg <= c_frac_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;
    assign out_mv    = c_mv_reg;
    assign out_frac  = c_frac_reg;

endmodule

@@ design/battery_safety_supervisor_unit.sv @@
// ---------------------------------------------------------------------------
// battery_safety_supervisor_unit
// battery minimum tracking, fault latch, warning cooldowns and safety state
// ---------------------------------------------------------------------------
// The block takes one item per clock cycle while the pipeline advances and
// returns one result per item, in order. The recovery product is formed in the
// input register stage, split into millivolts and microvolts over two stages,
// and the tracked minimum, fault latch, cooldown timers and safety state are
// updated as the item enters the result register. The pipeline advances
// whenever the result register is empty or its result is taken;
// configuration is taken at any time and must only change while the block is
// idle.
module battery_safety_supervisor_unit
    import bss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [VOLT_W-1:0]    voltage_mv,
    input  logic [ELAPSED_W-1:0] elapsed_ms,
    input  logic                 external_fault,
    input  logic                 operator_lost,
    input  logic                 link_lost,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           safety_state,
    output logic                 state_changed,
    output logic [VOLT_W-1:0]    min_voltage_mv,
    output logic [1:0]           battery_event,
    output logic                 scan_hold,
    output logic                 hold_changed
);

    localparam int TSUM_W = ((TIMER_BITS > ELAPSED_W) ? TIMER_BITS : ELAPSED_W) + 1;

    // configuration
    logic [13:0] critical_mv_reg;
    logic [13:0] warning_mv_reg;
    logic [10:0] near_margin_mv_reg;
    logic [13:0] recovery_rate_reg;
    logic [15:0] critical_cooldown_ms_reg;
    logic [15:0] warning_cooldown_ms_reg;
    logic        monitor_enable_reg;

    // pipeline
    logic              en;
    logic              a_valid_reg;
    item_t             a_item_reg;
    logic [PROD_W-1:0] a_prod_reg;
    item_t             in_item;
    logic              c_valid;
    item_t             c_item;
    logic [VOLT_W-1:0] c_mv;
    logic [FRAC_W-1:0] c_frac;
    logic              step;

    // tracked state
    logic [VOLT_W-1:0]     min_mv_reg;
    logic [VOLT_W-1:0]     min_mv_next;
    logic [FRAC_W-1:0]     min_frac_reg;
    logic [FRAC_W-1:0]     min_frac_next;
    logic                  battery_fault_reg;
    logic                  battery_fault_next;
    logic                  prev_stop_reg;
    logic                  prev_stop_next;
    logic [1:0]            mode_reg;
    logic [1:0]            mode_next;
    logic [TIMER_BITS-1:0] crit_quiet_reg;
    logic [TIMER_BITS-1:0] crit_quiet_next;
    logic [TIMER_BITS-1:0] warn_quiet_reg;
    logic [TIMER_BITS-1:0] warn_quiet_next;

    // result register
    logic              out_valid_reg;
    logic [1:0]        safety_state_reg;
    logic [1:0]        safety_state_next;
    logic              state_changed_reg;
    logic              state_changed_next;
    logic [VOLT_W-1:0] min_voltage_mv_reg;
    logic [VOLT_W-1:0] min_voltage_mv_next;
    logic [1:0]        battery_event_reg;
    logic [1:0]        battery_event_next;
    logic              scan_hold_reg;
    logic              scan_hold_next;
    logic              hold_changed_reg;
    logic              hold_changed_next;

    // tick datapath
    logic [FRAC_W:0]   frac_sum;
    logic              frac_carry;
    logic [FRAC_W-1:0] frac_adj;
    logic [VOLT_W:0]   mv_sum;
    logic [VOLT_W:0]   clip_mv;
    logic [FRAC_W-1:0] clip_frac;
    logic [VOLT_W-1:0] trk_mv;
    logic [FRAC_W-1:0] trk_frac;
    logic [TSUM_W-1:0] crit_sum;
    logic [TSUM_W-1:0] warn_sum;
    logic [TIMER_BITS-1:0] crit_adv;
    logic [TIMER_BITS-1:0] warn_adv;
    logic              stop_in;
    logic              stop;
    logic [VOLT_W:0]   near_level;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            critical_mv_reg          <= 14'd6600;
            warning_mv_reg           <= 14'd7000;
            near_margin_mv_reg       <= 11'd300;
            recovery_rate_reg        <= 14'd100;
            critical_cooldown_ms_reg <= 16'd5000;
            warning_cooldown_ms_reg  <= 16'd10000;
            monitor_enable_reg       <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CRITICAL_MV:   critical_mv_reg          <= cfg_data[13:0];
                REG_WARNING_MV:    warning_mv_reg           <= cfg_data[13:0];
                REG_NEAR_MARGIN:   near_margin_mv_reg       <= cfg_data[10:0];
                REG_RECOVERY_RATE: recovery_rate_reg        <= cfg_data[13:0];
                REG_CRIT_COOLDOWN: critical_cooldown_ms_reg <= cfg_data;
                REG_WARN_COOLDOWN: warning_cooldown_ms_reg  <= cfg_data;
                REG_MONITOR_EN:    monitor_enable_reg       <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // input stage
    always_comb
    begin
        in_item.func           = func;
        in_item.voltage_mv     = voltage_mv;
        in_item.elapsed_ms     = elapsed_ms;
        in_item.external_fault = external_fault;
        in_item.operator_lost  = operator_lost;
        in_item.link_lost      = link_lost;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg <= in_item;
            a_prod_reg <= PROD_W'(recovery_rate_reg) * PROD_W'(elapsed_ms);
        end
    end

    bss_split u_split
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .in_item   (a_item_reg),
        .in_prod   (a_prod_reg),
        .out_valid (c_valid),
        .out_item  (c_item),
        .out_mv    (c_mv),
        .out_frac  (c_frac)
    );

    assign step = en && c_valid;

    // minimum recovery and clamps
    assign frac_sum   = {1'b0, min_frac_reg} + {1'b0, c_frac};
    assign frac_carry = frac_sum >= (FRAC_W + 1)'(UV_PER_MV);
    assign frac_adj   = frac_carry ? FRAC_W'(frac_sum - (FRAC_W + 1)'(UV_PER_MV))
                                   : frac_sum[FRAC_W-1:0];
    assign mv_sum     = {1'b0, min_mv_reg} + {1'b0, c_mv} + {{VOLT_W{1'b0}}, frac_carry};

    always_comb
    begin
        if ((mv_sum > {1'b0, c_item.voltage_mv})
            || ((mv_sum == {1'b0, c_item.voltage_mv}) && (frac_adj != '0)))
        begin
            clip_mv   = {1'b0, c_item.voltage_mv};
            clip_frac = '0;
        end
        else
        begin
            clip_mv   = mv_sum;
            clip_frac = frac_adj;
        end

        if ((clip_mv > {1'b0, TEN_VOLTS_MV})
            || ((clip_mv == {1'b0, TEN_VOLTS_MV}) && (clip_frac != '0)))
        begin
            trk_mv   = TEN_VOLTS_MV;
            trk_frac = '0;
        end
        else
        begin
            trk_mv   = clip_mv[VOLT_W-1:0];
            trk_frac = clip_frac;
        end
    end

    // saturating quiet timers
    assign crit_sum = TSUM_W'(crit_quiet_reg) + TSUM_W'(c_item.elapsed_ms);
    assign warn_sum = TSUM_W'(warn_quiet_reg) + TSUM_W'(c_item.elapsed_ms);
    assign crit_adv = (crit_sum > TSUM_W'(TIMER_MAX)) ? TIMER_MAX : crit_sum[TIMER_BITS-1:0];
    assign warn_adv = (warn_sum > TSUM_W'(TIMER_MAX)) ? TIMER_MAX : warn_sum[TIMER_BITS-1:0];

    assign stop_in    = battery_fault_reg || c_item.external_fault;
    assign near_level = {1'b0, critical_mv_reg} + (VOLT_W + 1)'(near_margin_mv_reg);

    always_comb
    begin
        min_mv_next         = min_mv_reg;
        min_frac_next       = min_frac_reg;
        battery_fault_next  = battery_fault_reg;
        prev_stop_next      = prev_stop_reg;
        mode_next           = mode_reg;
        crit_quiet_next     = crit_quiet_reg;
        warn_quiet_next     = warn_quiet_reg;
        stop                = stop_in;
        battery_event_next  = EV_NONE;
        safety_state_next   = mode_reg;
        state_changed_next  = 1'b0;
        min_voltage_mv_next = TEN_VOLTS_MV;
        scan_hold_next      = prev_stop_reg;
        hold_changed_next   = 1'b0;

        if (c_item.func == FUNC_CLEAR)
        begin
            battery_fault_next = 1'b0;
            min_mv_next        = TEN_VOLTS_MV;
            min_frac_next      = '0;
        end
        else
        begin
            crit_quiet_next = crit_adv;
            warn_quiet_next = warn_adv;

            if (monitor_enable_reg)
            begin
                min_mv_next   = trk_mv;
                min_frac_next = trk_frac;

                if ((trk_mv < critical_mv_reg) && !stop_in)
                begin
                    battery_fault_next = 1'b1;
                    stop               = 1'b1;
                    battery_event_next = EV_CRITICAL;
                end
                else if ({1'b0, c_item.voltage_mv} < near_level)
                begin
                    if (TSUM_W'(crit_adv) >= TSUM_W'(critical_cooldown_ms_reg))
                    begin
                        battery_event_next = EV_NEAR;
                        crit_quiet_next    = '0;
                    end
                end
                else if (c_item.voltage_mv < warning_mv_reg)
                begin
                    if (TSUM_W'(warn_adv) >= TSUM_W'(warning_cooldown_ms_reg))
                    begin
                        battery_event_next = EV_LOW;
                        warn_quiet_next    = '0;
                    end
                end
            end

            hold_changed_next = stop != prev_stop_reg;
            prev_stop_next    = stop;

            if (stop)
            begin
                mode_next = ST_STOP;
            end
            else if (c_item.link_lost)
            begin
                mode_next = ST_CONN_LOSS;
            end
            else if (c_item.operator_lost)
            begin
                mode_next = ST_OPER_LOSS;
            end
            else
            begin
                mode_next = ST_CLEAR;
            end

            state_changed_next  = mode_next != mode_reg;
            safety_state_next   = mode_next;
            min_voltage_mv_next = min_mv_next;
            scan_hold_next      = stop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mv_reg        <= TEN_VOLTS_MV;
            min_frac_reg      <= '0;
            battery_fault_reg <= 1'b0;
            prev_stop_reg     <= 1'b0;
            mode_reg          <= ST_CLEAR;
            crit_quiet_reg    <= TIMER_MAX;
            warn_quiet_reg    <= TIMER_MAX;
        end
        else if (step)
        begin
            min_mv_reg        <= min_mv_next;
            min_frac_reg      <= min_frac_next;
            battery_fault_reg <= battery_fault_next;
            prev_stop_reg     <= prev_stop_next;
            mode_reg          <= mode_next;
            crit_quiet_reg    <= crit_quiet_next;
            warn_quiet_reg    <= warn_quiet_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            safety_state_reg   <= safety_state_next;
            state_changed_reg  <= state_changed_next;
            min_voltage_mv_reg <= min_voltage_mv_next;
            battery_event_reg  <= battery_event_next;
            scan_hold_reg      <= scan_hold_next;
            hold_changed_reg   <= hold_changed_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign safety_state   = safety_state_reg;
    assign state_changed  = state_changed_reg;
    assign min_voltage_mv = min_voltage_mv_reg;
    assign battery_event  = battery_event_reg;
    assign scan_hold      = scan_hold_reg;
    assign hold_changed   = hold_changed_reg;

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the battery safety supervisor
// ---------------------------------------------------------------------------
// Ticks and clear items are driven over the input handshake while results are
// taken with random back-pressure. A scoreboard class keeps its own copy of the
// registers, the tracked minimum, fault latch, cooldown timers and safety
// state, predicts one result per accepted item and checks each result in
// order. A directed pass walks trip, near-critical, low, cooldown, external
// stop, clear and monitoring-off cases; random phases then run under several
// register settings, from all zeros but the monitor enable to all ones,
// with the sender and the receiver stalling in turn.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bss_pkg::*;

    localparam logic [2:0]  REG_UNUSED    = 3'd7;
    localparam logic [23:0] FULL_SCALE_UV = 24'd10000000;
    localparam int          STALL_LIMIT   = 4000;
    localparam int          PHASE_ITEMS   = 65;
    localparam int          NUM_PHASES    = 6;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [1:0]        safety_state;
        logic              state_changed;
        logic [VOLT_W-1:0] min_voltage_mv;
        logic [1:0]        battery_event;
        logic              scan_hold;
        logic              hold_changed;
    } result_t;

    class supervisor_scoreboard;
        logic [VOLT_W-1:0]     crit_mv;
        logic [VOLT_W-1:0]     warn_mv;
        logic [10:0]           margin;
        logic [RATE_W-1:0]     rate;
        logic [15:0]           crit_cool;
        logic [15:0]           warn_cool;
        logic                  mon_en;
        logic [23:0]           min_uv;
        logic                  fault_latched;
        logic                  prev_stop;
        logic [1:0]            mode_now;
        logic [TIMER_BITS-1:0] crit_quiet;
        logic [TIMER_BITS-1:0] warn_quiet;
        result_t               expected_results[$];
        int                    mismatches;

        function new();
            crit_mv       = 6600;
            warn_mv       = 7000;
            margin        = 300;
            rate          = 100;
            crit_cool     = 5000;
            warn_cool     = 10000;
            mon_en        = 1'b1;
            min_uv        = FULL_SCALE_UV;
            fault_latched = 1'b0;
            prev_stop     = 1'b0;
            mode_now      = ST_CLEAR;
            crit_quiet    = TIMER_MAX;
            warn_quiet    = TIMER_MAX;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_CRITICAL_MV:   crit_mv   = data[VOLT_W-1:0];
                REG_WARNING_MV:    warn_mv   = data[VOLT_W-1:0];
                REG_NEAR_MARGIN:   margin    = data[10:0];
                REG_RECOVERY_RATE: rate      = data[RATE_W-1:0];
                REG_CRIT_COOLDOWN: crit_cool = data;
                REG_WARN_COOLDOWN: warn_cool = data;
                REG_MONITOR_EN:    mon_en    = data[0];
                default: ;
            endcase
        endfunction

        function logic [TIMER_BITS-1:0] timer_advance(logic [TIMER_BITS-1:0] t,
                                                      logic [ELAPSED_W-1:0] d);
            logic [TIMER_BITS:0] s;
            s = {1'b0, t} + d;
            return (s > TIMER_MAX) ? TIMER_MAX : s[TIMER_BITS-1:0];
        endfunction

        function void note_item(item_t it);
            result_t    r;
            logic       stop_on;
            logic [1:0] next_mode;
            u64_t       m;
            u64_t       v_uv;
            r = '0;
            if (it.func == FUNC_CLEAR)
            begin
                fault_latched    = 1'b0;
                min_uv           = FULL_SCALE_UV;
                r.safety_state   = mode_now;
                r.min_voltage_mv = VOLT_W'(min_uv / 1000);
                r.battery_event  = EV_NONE;
                r.scan_hold      = prev_stop;
            end
            else
            begin
                stop_on         = fault_latched | it.external_fault;
                crit_quiet      = timer_advance(crit_quiet, it.elapsed_ms);
                warn_quiet      = timer_advance(warn_quiet, it.elapsed_ms);
                r.battery_event = EV_NONE;
                if (mon_en)
                begin
                    m    = u64_t'(min_uv) + u64_t'(rate) * u64_t'(it.elapsed_ms);
                    v_uv = u64_t'(it.voltage_mv) * 1000;
                    if (m > v_uv)
                        m = v_uv;
                    if (m > FULL_SCALE_UV)
                        m = FULL_SCALE_UV;
                    min_uv = m[23:0];
                    if (m < u64_t'(crit_mv) * 1000 && !stop_on)
                    begin
                        fault_latched   = 1'b1;
                        stop_on         = 1'b1;
                        r.battery_event = EV_CRITICAL;
                    end
                    else if (u64_t'(it.voltage_mv) < u64_t'(crit_mv) + u64_t'(margin))
                    begin
                        if (crit_quiet >= crit_cool)
                        begin
                            r.battery_event = EV_NEAR;
                            crit_quiet      = '0;
                        end
                    end
                    else if (it.voltage_mv < warn_mv)
                    begin
                        if (warn_quiet >= warn_cool)
                        begin
                            r.battery_event = EV_LOW;
                            warn_quiet      = '0;
                        end
                    end
                end
                r.hold_changed = (stop_on != prev_stop);
                prev_stop      = stop_on;
                if (stop_on)
                    next_mode = ST_STOP;
                else if (it.link_lost)
                    next_mode = ST_CONN_LOSS;
                else if (it.operator_lost)
                    next_mode = ST_OPER_LOSS;
                else
                    next_mode = ST_CLEAR;
                r.state_changed  = (next_mode != mode_now);
                mode_now         = next_mode;
                r.safety_state   = next_mode;
                r.min_voltage_mv = VOLT_W'(min_uv / 1000);
                r.scan_hold      = stop_on;
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: state %0d min %0d event %0d hold %0b",
                             got.safety_state, got.min_voltage_mv, got.battery_event,
                             got.scan_hold);
                return;
            end
            want = expected_results.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch (exp/act): state %0d/%0d changed %0b/%0b ",
                              "min %0d/%0d event %0d/%0d hold %0b/%0b hold_chg %0b/%0b"},
                             want.safety_state, got.safety_state,
                             want.state_changed, got.state_changed,
                             want.min_voltage_mv, got.min_voltage_mv,
                             want.battery_event, got.battery_event,
                             want.scan_hold, got.scan_hold,
                             want.hold_changed, got.hold_changed);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [2:0]           cfg_index;
    logic [15:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 func;
    logic [VOLT_W-1:0]    voltage_mv;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 external_fault;
    logic                 operator_lost;
    logic                 link_lost;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           safety_state;
    logic                 state_changed;
    logic [VOLT_W-1:0]    min_voltage_mv;
    logic [1:0]           battery_event;
    logic                 scan_hold;
    logic                 hold_changed;

    supervisor_scoreboard sb;
    int                   src_idle_pct;
    int                   sink_idle_pct;
    int                   quiet_cycles;

    battery_safety_supervisor_unit i_dut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= sink_idle_pct);

    // transfer monitor, scoreboard update and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result({safety_state, state_changed, min_voltage_mv,
                                 battery_event, scan_hold, hold_changed});
            if (in_valid && in_ready)
                sb.note_item({func, voltage_mv, elapsed_ms, external_fault,
                              operator_lost, link_lost});
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if ((out_valid && out_ready) || (in_valid && in_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic item_t mk_item(logic f, int v, int e, logic x, logic il, logic cl);
        item_t it;
        it.func           = f;
        it.voltage_mv     = v[VOLT_W-1:0];
        it.elapsed_ms     = e[ELAPSED_W-1:0];
        it.external_fault = x;
        it.operator_lost  = il;
        it.link_lost      = cl;
        return it;
    endfunction

    task automatic send_item(item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        func           <= it.func;
        voltage_mv     <= it.voltage_mv;
        elapsed_ms     <= it.elapsed_ms;
        external_fault <= it.external_fault;
        operator_lost  <= it.operator_lost;
        link_lost      <= it.link_lost;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] vals [0:6];
        item_t       it;
        int          sel;
        int          anchor;
        int          v;
        int          e;

        sb             = new();
        quiet_cycles   = 0;
        src_idle_pct   = 0;
        sink_idle_pct  = 0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        func           = FUNC_TICK;
        voltage_mv     = '0;
        elapsed_ms     = '0;
        external_fault = 1'b0;
        operator_lost  = 1'b0;
        link_lost      = 1'b0;
        out_ready      = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed pass at reset settings
        send_item(mk_item(FUNC_TICK, 10000, 0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(FUNC_TICK, 16383, 65535, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(FUNC_TICK, 7200, 0, 1'b0, 1'b0, 1'b1));
        send_item(mk_item(FUNC_TICK, 6950, 100, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(FUNC_TICK, 6950, 100, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(FUNC_TICK, 6800, 10, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(FUNC_TICK, 6850, 10, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(FUNC_TICK, 6500, 0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(FUNC_TICK, 6500, 0, 1'b0, 1'b1, 1'b1));
        send_item(mk_item(FUNC_CLEAR, 16383, 65535, 1'b1, 1'b1, 1'b1));
        send_item(mk_item(FUNC_TICK, 8000, 0, 1'b1, 1'b0, 1'b0));
        send_item(mk_item(FUNC_TICK, 6000, 0, 1'b1, 1'b0, 1'b0));
        send_item(mk_item(FUNC_TICK, 10000, 65535, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(FUNC_TICK, 0, 0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(FUNC_CLEAR, 0, 0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(FUNC_TICK, 0, 0, 1'b1, 1'b1, 1'b0));
        send_item(mk_item(FUNC_CLEAR, 0, 0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(FUNC_TICK, 9000, 65535, 1'b0, 1'b0, 1'b1));
        wait_drain();

        // monitoring off, plus a write to the unused index
        write_cfg(REG_MONITOR_EN, 16'd0);
        write_cfg(REG_UNUSED, 16'hFFFF);
        send_item(mk_item(FUNC_TICK, 0, 0, 1'b0, 1'b0, 1'b0));
        send_item(mk_item(FUNC_TICK, 16383, 5000, 1'b0, 1'b1, 1'b0));
        send_item(mk_item(FUNC_TICK, 3000, 20, 1'b0, 1'b0, 1'b1));
        wait_drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    vals[REG_CRITICAL_MV]   = 16'd6600;
                    vals[REG_WARNING_MV]    = 16'd7000;
                    vals[REG_NEAR_MARGIN]   = 16'd300;
                    vals[REG_RECOVERY_RATE] = 16'd100;
                    vals[REG_CRIT_COOLDOWN] = 16'd5000;
                    vals[REG_WARN_COOLDOWN] = 16'd10000;
                    vals[REG_MONITOR_EN]    = 16'd1;
                end
                1:
                begin
                    foreach (vals[r])
                        vals[r] = 16'd0;
                    vals[REG_MONITOR_EN] = 16'd1;
                end
                2:
                begin
                    vals[REG_CRITICAL_MV]   = 16'd10000;
                    vals[REG_WARNING_MV]    = 16'd10000;
                    vals[REG_NEAR_MARGIN]   = 16'd2000;
                    vals[REG_RECOVERY_RATE] = 16'd10000;
                    vals[REG_CRIT_COOLDOWN] = 16'd65535;
                    vals[REG_WARN_COOLDOWN] = 16'd65535;
                    vals[REG_MONITOR_EN]    = 16'd1;
                end
                4:
                begin
                    foreach (vals[r])
                        vals[r] = 16'hFFFF;
                end
                default:
                begin
                    vals[REG_CRITICAL_MV]   = 16'($urandom_range(5000, 8000));
                    vals[REG_WARNING_MV]    = 16'($urandom_range(6000, 9000));
                    vals[REG_NEAR_MARGIN]   = 16'($urandom_range(0, 2000));
                    vals[REG_RECOVERY_RATE] = 16'($urandom_range(0, 10000));
                    vals[REG_CRIT_COOLDOWN] = 16'($urandom_range(0, 8000));
                    vals[REG_WARN_COOLDOWN] = 16'($urandom_range(0, 15000));
                    vals[REG_MONITOR_EN]    = (ph == 3) ? 16'd0 : 16'd1;
                end
            endcase
            for (int r = 0; r <= REG_MONITOR_EN; r++)
                write_cfg(r[2:0], vals[r]);
            if (ph == 5)
                write_cfg(REG_UNUSED, 16'($urandom));

            src_idle_pct  = (ph < 2) ? 11 : (ph < 4) ? 83 : 0;
            sink_idle_pct = (ph < 2) ? 83 : (ph < 4) ? 11 : 0;

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                sel = $urandom_range(99);
                if (sel < 60)
                begin
                    anchor = ($urandom_range(1) != 0) ? int'(sb.warn_mv)
                                                      : int'(sb.crit_mv) + int'(sb.margin);
                    v = anchor + $urandom_range(800) - 400;
                    if (v < 0)
                        v = 0;
                    if (v > 16383)
                        v = 16383;
                end
                else if (sel < 85)
                    v = $urandom_range(10000);
                else
                    v = $urandom_range(16383);
                sel = $urandom_range(99);
                if (sel < 70)
                    e = $urandom_range(1500);
                else if (sel < 90)
                    e = $urandom_range(20000);
                else if (sel < 95)
                    e = 65535;
                else
                    e = $urandom_range(65535);
                it = mk_item(($urandom_range(99) < 6) ? FUNC_CLEAR : FUNC_TICK, v, e,
                             $urandom_range(99) < 8, $urandom_range(99) < 30,
                             $urandom_range(99) < 30);
                send_item(it);
            end
            wait_drain();
        end

        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
